@@ src/ecr_pkg.sv @@
// Package for the elastic collision response core.
// Holds the shared item types, pipeline sizes and lane assignments.
// No dependencies.
package ecr_pkg;

  localparam int unsigned VEC_W       = 32;
  localparam int unsigned RATIO_BITS  = 28;
  localparam int unsigned SQRT_STEPS  = 32;
  localparam int unsigned DIV_QW      = 29;
  localparam int unsigned DIV_RW      = 33;
  localparam int unsigned DIV_AW      = DIV_RW + DIV_QW;
  localparam int unsigned DIV_LANES   = 5;
  localparam int unsigned LANE_RAT_A  = 3;
  localparam int unsigned LANE_RAT_B  = 4;
  localparam int unsigned STATIC_A    = 0;
  localparam int unsigned STATIC_B    = 1;

  // One colliding pair as it arrives on the input channel.
  typedef struct packed {
    logic [2:0][VEC_W-1:0] sep;
    logic [2:0][VEC_W-1:0] va;
    logic [2:0][VEC_W-1:0] vb;
    logic [VEC_W-1:0]      ma;
    logic [VEC_W-1:0]      mb;
    logic [1:0]            stat;
  } ecr_pair_t;

  // Data that travels alongside the arithmetic through the pipeline.
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][VEC_W-1:0] mag;
    logic [2:0][VEC_W-1:0] va;
    logic [2:0][VEC_W-1:0] vb;
    logic [VEC_W-1:0]      ma;
    logic [VEC_W-1:0]      mb;
    logic [VEC_W:0]        msum;
    logic [1:0]            stat;
    logic                  degen;
  } ecr_side_t;

endpackage

@@ src/ecr_prep.sv @@
// Front stages: separation magnitudes, normalizing shift and squared length.
// Depends on ecr_pkg.
module ecr_prep (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  ecr_pkg::ecr_pair_t   in_pair,
  output logic                 out_valid,
  output ecr_pkg::ecr_side_t   out_side,
  output logic [63:0]          out_l2
);

  logic                v1, v2, v3, v4, v5;
  ecr_pkg::ecr_side_t  side1, side2, side3, side4, side5;
  logic [4:0]          shamt2;
  logic [2:0][63:0]    sq4;
  logic [63:0]         l2_5;

  ecr_pkg::ecr_side_t  side1_next, side2_next, side3_next;
  logic [4:0]          shamt2_next;
  logic [31:0]         mx;
  logic [4:0]          msb;

  always_comb begin
    side1_next       = '0;
    side1_next.va    = in_pair.va;
    side1_next.vb    = in_pair.vb;
    side1_next.ma    = in_pair.ma;
    side1_next.mb    = in_pair.mb;
    side1_next.stat  = in_pair.stat;
    side1_next.msum  = {1'b0, in_pair.ma} + {1'b0, in_pair.mb};
    for (int i = 0; i < 3; i++) begin
      side1_next.neg[i] = in_pair.sep[i][31];
      side1_next.mag[i] = in_pair.sep[i][31] ? (~in_pair.sep[i] + 32'd1) : in_pair.sep[i];
    end
  end

  // Largest magnitude and the shift that brings it into [2^30, 2^31].
  always_comb begin
    mx = side1.mag[0];
    if (side1.mag[1] > mx) mx = side1.mag[1];
    if (side1.mag[2] > mx) mx = side1.mag[2];
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (mx[i]) msb = 5'(i);
    end
    shamt2_next      = (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
    side2_next       = side1;
    side2_next.degen = (mx == '0) || (side1.msum == '0);
  end

  always_comb begin
    side3_next = side2;
    for (int i = 0; i < 3; i++) begin
      side3_next.mag[i] = side2.mag[i] << shamt2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1  <= side1_next;
      side2  <= side2_next;
      shamt2 <= shamt2_next;
      side3  <= side3_next;
      side4  <= side3;
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= side3.mag[i] * side3.mag[i];
      end
      side5  <= side4;
      l2_5   <= sq4[0] + sq4[1] + sq4[2];
    end
  end

  assign out_valid = v5;
  assign out_side  = side5;
  assign out_l2    = l2_5;

endmodule

@@ src/ecr_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on ecr_pkg.
module ecr_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  ecr_pkg::ecr_side_t  in_side,
  input  logic [63:0]         in_l2,
  output logic                out_valid,
  output ecr_pkg::ecr_side_t  out_side,
  output logic [31:0]         out_len
);

  localparam int N = ecr_pkg::SQRT_STEPS;

  logic               val_q  [N];
  logic [63:0]        rem_q  [N];
  logic [63:0]        root_q [N];
  ecr_pkg::ecr_side_t side_q [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic               val_in;
    logic [63:0]        rem_in, root_in, trial;
    ecr_pkg::ecr_side_t side_in;

    if (j == 0) begin : g_first
      assign val_in  = in_valid;
      assign rem_in  = in_l2;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign val_in  = val_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign trial = root_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        val_q[j] <= 1'b0;
      end else if (en) begin
        val_q[j] <= val_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[j] <= side_in;
        if (rem_in >= trial) begin
          rem_q[j]  <= rem_in - trial;
          root_q[j] <= (root_in >> 1) + BIT;
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in >> 1;
        end
      end
    end
  end

  assign out_valid = val_q[N-1];
  assign out_side  = side_q[N-1];
  assign out_len   = root_q[N-1][31:0];

endmodule

@@ src/ecr_div.sv @@
// Pipelined restoring divider over several lanes, one quotient bit per stage.
// Depends on ecr_pkg.
module ecr_div #(
  parameter int LANES = 5,
  parameter int SW    = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_valid,
  input  logic [SW-1:0]                               in_side,
  input  logic [LANES-1:0][ecr_pkg::DIV_AW-1:0]       in_num,
  input  logic [LANES-1:0][ecr_pkg::DIV_RW-1:0]       in_den,
  output logic                                        out_valid,
  output logic [SW-1:0]                               out_side,
  output logic [LANES-1:0][ecr_pkg::DIV_QW-1:0]       out_quo
);

  localparam int N  = ecr_pkg::DIV_QW;
  localparam int AW = ecr_pkg::DIV_AW;
  localparam int RW = ecr_pkg::DIV_RW;

  // The accumulator holds the partial remainder on top and the remaining
  // dividend bits below; quotient bits shift in at the bottom.
  logic                          val_q  [N];
  logic [SW-1:0]                 side_q [N];
  logic [LANES-1:0][AW-1:0]      acc_q  [N];
  logic [LANES-1:0][RW-1:0]      den_q  [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    logic                     val_in;
    logic [SW-1:0]            side_in;
    logic [LANES-1:0][AW-1:0] acc_in, acc_next;
    logic [LANES-1:0][RW-1:0] den_in;
    logic [LANES-1:0][RW:0]   part, diff;
    logic [LANES-1:0]         ge;

    if (j == 0) begin : g_first
      assign val_in  = in_valid;
      assign side_in = in_side;
      assign acc_in  = in_num;
      assign den_in  = in_den;
    end else begin : g_next
      assign val_in  = val_q[j-1];
      assign side_in = side_q[j-1];
      assign acc_in  = acc_q[j-1];
      assign den_in  = den_q[j-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        part[l]     = acc_in[l][AW-1 -: RW+1];
        ge[l]       = part[l] >= {1'b0, den_in[l]};
        diff[l]     = ge[l] ? part[l] - {1'b0, den_in[l]} : part[l];
        acc_next[l] = {diff[l][RW-1:0], acc_in[l][N-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val_q[j] <= 1'b0;
      end else if (en) begin
        val_q[j] <= val_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[j] <= side_in;
        acc_q[j]  <= acc_next;
        den_q[j]  <= den_in;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = acc_q[N-1][l][N-1:0];
    end
  end

  assign out_valid = val_q[N-1];
  assign out_side  = side_q[N-1];

endmodule

@@ src/ecr_imp.sv @@
// Impulse stages: signed normal, closing speed, mass-weighted impulse and
// saturated velocity update. Depends on ecr_pkg.
module ecr_imp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  ecr_pkg::ecr_side_t                            in_side,
  input  logic [ecr_pkg::DIV_LANES-1:0][ecr_pkg::DIV_QW-1:0] in_quo,
  output logic                                          out_valid,
  output logic [2:0][31:0]                              out_va,
  output logic [2:0][31:0]                              out_vb,
  output logic                                          out_degen
);

  localparam int NW    = FRAC_BITS + 2;
  localparam int PW    = 32 + NW;
  localparam int DFW   = PW + 3;
  localparam int TW    = DFW + 2 - FRAC_BITS;
  localparam int RTW   = ecr_pkg::DIV_QW + 1;
  localparam int PAW   = TW + RTW;
  localparam int JW    = PAW + 1 - ecr_pkg::RATIO_BITS;
  localparam int MW    = JW + NW;
  localparam int CW    = MW + 1 - FRAC_BITS;
  localparam int RSW   = CW + 1;
  localparam int FHALF = 1 << (FRAC_BITS - 1);
  localparam int RHALF = 1 << (ecr_pkg::RATIO_BITS - 1);
  localparam int NST   = 8;

  logic                        v_q    [NST];
  ecr_pkg::ecr_side_t          side_q [7];
  logic signed [NW-1:0]        n_q    [6][3];
  logic [ecr_pkg::DIV_QW-1:0]  rat_q  [4][2];
  logic signed [PW-1:0]        pa, pb;
  logic signed [PW-1:0]        pa_q [3];
  logic signed [PW-1:0]        pb_q [3];
  logic signed [DFW-1:0]       dif_q;
  logic signed [TW-1:0]        tw_q;
  logic signed [PAW-1:0]       jpa_q, jpb_q;
  logic signed [JW-1:0]        ja_q, jb_q;
  logic signed [MW-1:0]        ma_q [3];
  logic signed [MW-1:0]        mb_q [3];

  logic signed [DFW+1:0]       tw_full;
  logic signed [PAW:0]         jta, jtb;
  logic signed [MW:0]          cta [3];
  logic signed [MW:0]          ctb [3];
  logic signed [RSW-1:0]       ra [3];
  logic signed [RSW-1:0]       rb [3];
  logic [2:0][31:0]            va_next, vb_next;

  assign pa = '0;
  assign pb = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
      for (int k = 1; k < NST; k++) v_q[k] <= v_q[k-1];
    end
  end

  // Closing speed doubled and rounded back to FRAC_BITS fraction bits.
  always_comb begin
    tw_full = ((DFW+2)'(dif_q) <<< 1) + (DFW+2)'(FHALF) - (DFW+2)'({1'b0, dif_q[DFW-1]});
    jta = (PAW+1)'(jpa_q) + (PAW+1)'(RHALF) - (PAW+1)'({1'b0, jpa_q[PAW-1]});
    jtb = (PAW+1)'(jpb_q) + (PAW+1)'(RHALF) - (PAW+1)'({1'b0, jpb_q[PAW-1]});
  end

  // Final update with rounding, saturation and the pass-through cases.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cta[i] = (MW+1)'(ma_q[i]) + (MW+1)'(FHALF) - (MW+1)'({1'b0, ma_q[i][MW-1]});
      ctb[i] = (MW+1)'(mb_q[i]) + (MW+1)'(FHALF) - (MW+1)'({1'b0, mb_q[i][MW-1]});
      ra[i]  = RSW'($signed(side_q[6].va[i])) - RSW'(cta[i] >>> FRAC_BITS);
      rb[i]  = RSW'($signed(side_q[6].vb[i])) + RSW'(ctb[i] >>> FRAC_BITS);
      if (side_q[6].degen || side_q[6].stat[ecr_pkg::STATIC_A]) begin
        va_next[i] = side_q[6].va[i];
      end else if (ra[i][RSW-1:31] != {(RSW-31){ra[i][RSW-1]}}) begin
        va_next[i] = ra[i][RSW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        va_next[i] = ra[i][31:0];
      end
      if (side_q[6].degen || side_q[6].stat[ecr_pkg::STATIC_B]) begin
        vb_next[i] = side_q[6].vb[i];
      end else if (rb[i][RSW-1:31] != {(RSW-31){rb[i][RSW-1]}}) begin
        vb_next[i] = rb[i][RSW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        vb_next[i] = rb[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= in_side;
      for (int k = 1; k < 7; k++) side_q[k] <= side_q[k-1];
      for (int i = 0; i < 3; i++) begin
        n_q[0][i] <= in_side.neg[i] ? -$signed({1'b0, in_quo[i][FRAC_BITS:0]})
                                    :  $signed({1'b0, in_quo[i][FRAC_BITS:0]});
        for (int k = 1; k < 6; k++) n_q[k][i] <= n_q[k-1][i];
      end
      rat_q[0][0] <= in_quo[ecr_pkg::LANE_RAT_A];
      rat_q[0][1] <= in_quo[ecr_pkg::LANE_RAT_B];
      for (int k = 1; k < 4; k++) rat_q[k] <= rat_q[k-1];

      for (int i = 0; i < 3; i++) begin
        pa_q[i] <= $signed(side_q[0].va[i]) * n_q[0][i];
        pb_q[i] <= $signed(side_q[0].vb[i]) * n_q[0][i];
      end
      dif_q <= DFW'(pa_q[0]) + DFW'(pa_q[1]) + DFW'(pa_q[2])
             - DFW'(pb_q[0]) - DFW'(pb_q[1]) - DFW'(pb_q[2]) + DFW'(pa) - DFW'(pb);
      tw_q  <= TW'(tw_full >>> FRAC_BITS);
      jpa_q <= tw_q * $signed({1'b0, rat_q[3][0]});
      jpb_q <= tw_q * $signed({1'b0, rat_q[3][1]});
      ja_q  <= JW'(jta >>> ecr_pkg::RATIO_BITS);
      jb_q  <= JW'(jtb >>> ecr_pkg::RATIO_BITS);
      for (int i = 0; i < 3; i++) begin
        ma_q[i] <= ja_q * n_q[5][i];
        mb_q[i] <= jb_q * n_q[5][i];
      end
      out_va    <= va_next;
      out_vb    <= vb_next;
      out_degen <= side_q[6].degen;
    end
  end

  assign out_valid = v_q[NST-1];

endmodule

@@ src/elastic_collision_response_core.sv @@
// Top level of the elastic collision response core.
// Depends on ecr_pkg, ecr_prep, ecr_sqrt, ecr_div and ecr_imp.
//
// Usage: each input beat on the s_axis channel carries one colliding pair:
// the separation A minus B, both velocities, both masses (all Q16.16 with
// FRAC_BITS fraction bits) and the two static flags. Each beat produces
// exactly one output beat on m_axis with the new velocities of A and B,
// saturated to 32 bits, and a degenerate flag in tuser that marks a zero
// separation or zero mass sum, in which case both velocities pass through.
// From input acceptance to m_axis_tvalid a pair passes five front
// stages, 32 square-root stages, 29 divider stages, eight impulse stages
// and the output register; the 32-bit root and 29-bit quotients, one bit
// per stage, set that depth. One pair per clock unless the pipe freezes.
// Reset clears every valid bit; payload registers are not reset.
// When the receiver stalls, the output register holds its beat and the
// pipeline keeps advancing until its last stage is occupied, so empty
// slots are squeezed out and s_axis_tready stays high meanwhile; only then
// the whole pipeline freezes. Nothing is dropped or repeated.
module elastic_collision_response_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sep_x, sep_y, sep_z, vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y,
  // vel_b_z, mass_a, mass_b (32 bits each), static_mask (2), zero pad (6)
  input  logic [359:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z (32 bits each)
  output logic [191:0] m_axis_tdata,
  // degenerate
  output logic         m_axis_tuser
);

  localparam int SW = $bits(ecr_pkg::ecr_side_t);
  localparam int AW = ecr_pkg::DIV_AW;
  localparam int RW = ecr_pkg::DIV_RW;

  logic                                           en;
  ecr_pkg::ecr_pair_t                             pair;
  logic                                           prep_valid, sq_valid, div_valid, imp_valid;
  ecr_pkg::ecr_side_t                             prep_side, sq_side, div_side;
  logic [SW-1:0]                                  div_side_vec;
  logic [63:0]                                    prep_l2;
  logic [31:0]                                    sq_len;
  logic [ecr_pkg::DIV_LANES-1:0][AW-1:0]          div_num;
  logic [ecr_pkg::DIV_LANES-1:0][RW-1:0]          div_den;
  logic [ecr_pkg::DIV_LANES-1:0][ecr_pkg::DIV_QW-1:0] div_quo;
  logic [2:0][31:0]                               imp_va, imp_vb;
  logic                                           imp_degen;

  // One enable for every stage. The pipe only freezes when the output
  // register holds an untaken beat and another one waits right behind it.
  assign en            = !m_axis_tvalid || m_axis_tready || !imp_valid;
  assign s_axis_tready = en;

  assign pair.sep[0] = s_axis_tdata[31:0];
  assign pair.sep[1] = s_axis_tdata[63:32];
  assign pair.sep[2] = s_axis_tdata[95:64];
  assign pair.va[0]  = s_axis_tdata[127:96];
  assign pair.va[1]  = s_axis_tdata[159:128];
  assign pair.va[2]  = s_axis_tdata[191:160];
  assign pair.vb[0]  = s_axis_tdata[223:192];
  assign pair.vb[1]  = s_axis_tdata[255:224];
  assign pair.vb[2]  = s_axis_tdata[287:256];
  assign pair.ma     = s_axis_tdata[319:288];
  assign pair.mb     = s_axis_tdata[351:320];
  assign pair.stat   = s_axis_tdata[353:352];

  ecr_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid && s_axis_tready),
    .in_pair   (pair),
    .out_valid (prep_valid),
    .out_side  (prep_side),
    .out_l2    (prep_l2)
  );

  ecr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_valid),
    .in_side   (prep_side),
    .in_l2     (prep_l2),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_len   (sq_len)
  );

  // Divider lanes: three rounded normal components (magnitude scaled by
  // 2^FRAC_BITS over the length) and the two rounded mass ratios.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_num[i] = AW'({sq_side.mag[i], {FRAC_BITS{1'b0}}}) + AW'(sq_len >> 1);
      div_den[i] = RW'(sq_len);
    end
    div_num[ecr_pkg::LANE_RAT_A] = AW'({sq_side.mb, {ecr_pkg::RATIO_BITS{1'b0}}})
                                 + AW'(sq_side.msum >> 1);
    div_den[ecr_pkg::LANE_RAT_A] = sq_side.msum;
    div_num[ecr_pkg::LANE_RAT_B] = AW'({sq_side.ma, {ecr_pkg::RATIO_BITS{1'b0}}})
                                 + AW'(sq_side.msum >> 1);
    div_den[ecr_pkg::LANE_RAT_B] = sq_side.msum;
  end

  ecr_div #(
    .LANES (ecr_pkg::DIV_LANES),
    .SW    (SW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .in_num    (div_num),
    .in_den    (div_den),
    .out_valid (div_valid),
    .out_side  (div_side_vec),
    .out_quo   (div_quo)
  );

  assign div_side = div_side_vec;

  ecr_imp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_imp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .in_side   (div_side),
    .in_quo    (div_quo),
    .out_valid (imp_valid),
    .out_va    (imp_va),
    .out_vb    (imp_vb),
    .out_degen (imp_degen)
  );

  // Output register: loads whenever it is empty or its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= imp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tdata <= {imp_vb, imp_va};
      m_axis_tuser <= imp_degen;
    end
  end

  // A held output beat may coexist with an advancing pipe only while the
  // last pipeline stage is empty.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready && s_axis_tready) |-> !imp_valid)
    else $error("pipeline advanced over a held output beat");

  // A frozen pipe keeps its finished beat at the last stage.
  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |=> imp_valid)
    else $error("finished beat lost while the pipeline was frozen");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

@@ dv/testbench.sv @@
// Testbench for elastic_collision_response_core: streams colliding pairs and
// checks every response beat against an in-bench fixed-point impulse predictor.
// Depends on ecr_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LATENCY = 75;

  typedef struct packed {
    logic [31:0] sx, sy, sz, ax, ay, az, bx, by, bz, ma, mb;
    logic [1:0]  stat;
  } pair_t;

  typedef struct packed {
    logic [191:0] vel;
    logic         degen;
  } response_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [359:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic         m_axis_tuser;

  elastic_collision_response_core #(.FRAC_BITS(FRAC)) DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pair_t     pending_pairs[$];
  response_t expected_responses[$];
  int        mismatch_count = 0;
  int        beats_checked = 0;
  int        degen_seen = 0;
  int        send_idle_pct = 16;
  int        recv_idle_pct = 54;
  int        hold_off = 0;
  bit        stimulus_done = 1'b0;
  string     field_names[6] = '{"new_a_x", "new_a_y", "new_a_z",
                                "new_b_x", "new_b_y", "new_b_z"};

  function automatic logic [359:0] pack_pair(pair_t p);
    return {6'b0, p.stat, p.mb, p.ma, p.bz, p.by, p.bx, p.az, p.ay, p.ax,
            p.sz, p.sy, p.sx};
  endfunction

  // Round v / 2^k to nearest, ties away from zero.
  function automatic longint round_shift(longint v, int k);
    longint half;
    half = longint'(1) << (k - 1);
    if (v >= 0) return (v + half) >>> k;
    return -((-v + half) >>> k);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // Impulse exchange along the normalized separation.
  function automatic response_t bounce(pair_t p);
    longint s[3], va[3], vb[3], ra[3], rb[3], n[3];
    longint unsigned mag[3], mx, len, msum, ma, mb, rat_a, rat_b;
    longint da, db, twod, ja, jb;
    response_t r;
    s[0] = longint'($signed(p.sx)); s[1] = longint'($signed(p.sy));
    s[2] = longint'($signed(p.sz));
    va[0] = longint'($signed(p.ax)); va[1] = longint'($signed(p.ay));
    va[2] = longint'($signed(p.az));
    vb[0] = longint'($signed(p.bx)); vb[1] = longint'($signed(p.by));
    vb[2] = longint'($signed(p.bz));
    ma = {32'd0, p.ma};
    mb = {32'd0, p.mb};
    msum = ma + mb;
    da = 0;
    db = 0;
    for (int i = 0; i < 3; i++) begin
      ra[i] = va[i];
      rb[i] = vb[i];
      mag[i] = s[i] < 0 ? -s[i] : s[i];
    end
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    r.degen = (mx == 0) || (msum == 0);
    if (!r.degen) begin
      while (mx < (64'd1 << 30)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      len = floor_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
      for (int i = 0; i < 3; i++) begin
        n[i] = ((mag[i] << FRAC) + (len >> 1)) / len;
        if (s[i] < 0) n[i] = -n[i];
        da += va[i] * n[i];
        db += vb[i] * n[i];
      end
      twod = round_shift((da - db) * 2, FRAC);
      rat_a = ((mb << ecr_pkg::RATIO_BITS) + (msum >> 1)) / msum;
      rat_b = ((ma << ecr_pkg::RATIO_BITS) + (msum >> 1)) / msum;
      ja = round_shift(twod * longint'(rat_a), ecr_pkg::RATIO_BITS);
      jb = round_shift(twod * longint'(rat_b), ecr_pkg::RATIO_BITS);
      for (int i = 0; i < 3; i++) begin
        if (!p.stat[ecr_pkg::STATIC_A])
          ra[i] = clamp32(va[i] - round_shift(ja * n[i], FRAC));
        if (!p.stat[ecr_pkg::STATIC_B])
          rb[i] = clamp32(vb[i] + round_shift(jb * n[i], FRAC));
      end
    end
    r.vel = {rb[2][31:0], rb[1][31:0], rb[0][31:0],
             ra[2][31:0], ra[1][31:0], ra[0][31:0]};
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH beat %0d %s: got %h want %h", beats_checked, what, got, want);
    mismatch_count++;
  endtask

  // Driver: offers the next pair unless idling; the prediction is made when
  // the beat is actually accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_responses.insert(expected_responses.size(),
                                  bounce(pending_pairs.pop_front()));
      end
      if ((!s_axis_tvalid || s_axis_tready) && pending_pairs.size() > 0 &&
          ($urandom_range(99) >= send_idle_pct ||
           (s_axis_tvalid && !s_axis_tready))) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_pair(pending_pairs[0]);
      end else if (s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure; a long hold-off counts down on its own.
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
    m_axis_tready <= !rst && hold_off <= 1 && $urandom_range(99) >= recv_idle_pct;
  end

  // Monitor: compares each accepted output beat with the oldest prediction.
  always @(posedge clk) begin
    response_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_responses.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = expected_responses.pop_front();
        for (int i = 0; i < 6; i++)
          if (m_axis_tdata[32*i +: 32] !== want.vel[32*i +: 32])
            report_mismatch(field_names[i], m_axis_tdata[32*i +: 32],
                            want.vel[32*i +: 32]);
        if (m_axis_tuser !== want.degen)
          report_mismatch("degenerate", {31'd0, m_axis_tuser}, {31'd0, want.degen});
        if (want.degen) degen_seen++;
      end
      beats_checked++;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom_range(255) - 128;
      4: return $urandom;
      default: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom)};
    if ($urandom_range(9) != 0) begin
      p.sx = rand_word(); p.sy = rand_word(); p.sz = rand_word();
      p.ax = rand_word(); p.ay = rand_word(); p.az = rand_word();
      p.bx = rand_word(); p.by = rand_word(); p.bz = rand_word();
      p.ma = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0100_0000);
      p.mb = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0100_0000);
      if ($urandom_range(19) == 0) {p.sx, p.sy, p.sz} = '0;
      if ($urandom_range(19) == 0) {p.ma, p.mb} = '0;
      if ($urandom_range(1)) p.stat = 2'b00;
    end
    return p;
  endfunction

  task automatic add_pair(pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  task automatic add_directed(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                              logic [31:0] v, logic [31:0] ma, logic [31:0] mb,
                              logic [1:0] stat);
    pair_t p;
    p = '{sx, sy, sz, v, -v, v, -v, v, 32'h1_0000, ma, mb, stat};
    add_pair(p);
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || s_axis_tvalid || expected_responses.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Head-on, diagonal, extremes, zero separation, zero mass, each static mask.
    add_directed(32'h1_0000, 0, 0, 32'h2_0000, 32'h1_0000, 32'h1_0000, 2'b00);
    add_directed(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h3_0000,
                 32'h2_0000, 32'h1_0000, 2'b00);
    add_directed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'hffff_ffff, 32'hffff_ffff, 2'b00);
    add_directed(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h1, 32'hffff_ffff, 2'b00);
    add_directed(1, 0, 0, 32'h7fff_ffff, 32'hffff_ffff, 1, 2'b00);
    add_directed(0, 0, 0, 32'h5_0000, 32'h1_0000, 32'h1_0000, 2'b00);
    add_directed(0, 0, 0, 32'h5_0000, 32'h1_0000, 32'h1_0000, 2'b11);
    add_directed(32'h1_0000, 0, 0, 32'h5_0000, 0, 0, 2'b01);
    add_directed(0, 32'hffff_0000, 0, 32'h4_0000, 32'h1_0000, 32'h3_0000, 2'b01);
    add_directed(0, 0, 32'h2_0000, 32'h4_0000, 32'h1_0000, 32'h3_0000, 2'b10);
    add_directed(32'h1234, 32'h5678, 32'h9abc, 32'h4_0000, 32'h1_0000, 0, 2'b11);
    add_directed(32'hffff_ffff, 32'hffff_ffff, 1, 32'hffff_ffff, 0, 32'h1, 2'b00);
    add_directed(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'haaaa_aaaa,
                 32'h5555_5555, 32'haaaa_aaaa, 2'b00);

    for (int i = 0; i < 300; i++) add_pair(rand_pair());
    // Long receiver stall while the sender keeps offering, to fill the core.
    wait (pending_pairs.size() < 250);
    hold_off = 400;
    drain();

    send_idle_pct = 54;
    recv_idle_pct = 16;
    for (int i = 0; i < 300; i++) add_pair(rand_pair());
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 300; i++) add_pair(rand_pair());
    drain();

    repeat (2 * LATENCY) @(posedge clk);
    $display("Checked %0d response beats (%0d degenerate) under three idle patterns",
             beats_checked, degen_seen);
    $display("and one long output stall.");
    if (mismatch_count == 0 && expected_responses.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d responses outstanding", expected_responses.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
